### design/circuit_id_port_extractor_core_defines.svh
// Assertion macros shared by the circuit-id port extractor RTL.
`ifndef CIRCUIT_ID_PORT_EXTRACTOR_CORE_DEFINES_SVH
`define CIRCUIT_ID_PORT_EXTRACTOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CIDPE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CIDPE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/cidpe_pkg.sv
// Types and constants shared by the circuit-id port extractor modules.
package cidpe_pkg;

	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned PORT_W   = 16;

	typedef logic [STATUS_W-1:0] status_t;

	// Result status codes.
	localparam status_t ST_OK       = 3'd0;
	localparam status_t ST_EMPTY    = 3'd1;
	localparam status_t ST_NO_SP1   = 3'd2;
	localparam status_t ST_NO_SP2   = 3'd3;
	localparam status_t ST_NO_COLON = 3'd4;

	// Characters the parser looks for.
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
	localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

	// Registered input byte as seen by the parser.
	typedef struct packed {
		logic              valid;
		logic [CHAR_W-1:0] char_in;
		logic              last;
	} byte_t;

	// Result handed from the parser to the output register.
	typedef struct packed {
		logic              push;
		status_t           status;
		logic [PORT_W-1:0] port;
	} res_t;

endpackage

### design/cidpe_in_if.sv
// Input byte channel of the circuit-id port extractor.
interface cidpe_in_if
	import cidpe_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_in;
	logic              last;

	modport source (output valid, output char_in, output last, input ready);
	modport sink (input valid, input char_in, input last, output ready);
endinterface

### design/cidpe_out_if.sv
// Result channel of the circuit-id port extractor.
interface cidpe_out_if
	import cidpe_pkg::*;
();
	logic              valid;
	logic              ready;
	status_t           status;
	logic [PORT_W-1:0] port;

	modport source (output valid, output status, output port, input ready);
	modport sink (input valid, input status, input port, output ready);
endinterface

### design/circuit_id_port_extractor_core.sv
// Circuit-id port extractor: takes a circuit-id string one byte per transfer and
// returns one status and decimal port result on the byte marked last. Bytes are taken
// at one per cycle unless a last byte is stalled; each byte passes an input register
// and combinational parse logic, and its result is written to the output register when
// the last byte leaves the input register. Only a last byte waits when the previous result
// is not yet taken, since the single output register must be free; while it waits, no
// further byte is taken. The port accumulator is PORT_BITS wide and saturates at its
// maximum; the port field carries its low 16 bits and is zero when status is not ok.
`include "circuit_id_port_extractor_core_defines.svh"

module circuit_id_port_extractor_core
	import cidpe_pkg::*;
#(
	parameter int unsigned PORT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	cidpe_in_if.sink    in_ch,
	cidpe_out_if.source out_ch
);

	byte_t byte_s1;
	res_t  res;
	logic  adv;
	logic  out_free;

	cidpe_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.adv     (adv),
		.byte_s1 (byte_s1)
	);

	cidpe_parser #(
		.PORT_BITS (PORT_BITS)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_s1  (byte_s1),
		.out_free (out_free),
		.adv      (adv),
		.res      (res)
	);

	cidpe_out_stage u_out_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.out_ch   (out_ch),
		.out_free (out_free)
	);

	// A failed parse never reports a port number.
	`CIDPE_ASSERT_NOW(a_port_zero_on_error, clk, arst_n, out_ch.valid && out_ch.status != ST_OK, out_ch.port == '0, "port nonzero with error status")

	// Only defined status codes leave the block.
	`CIDPE_ASSERT_NOW(a_status_known, clk, arst_n, out_ch.valid, out_ch.status == ST_OK || out_ch.status == ST_EMPTY || out_ch.status == ST_NO_SP1 || out_ch.status == ST_NO_SP2 || out_ch.status == ST_NO_COLON, "undefined status code")

	// A last byte waiting on a full output slot blocks the input.
	`CIDPE_ASSERT_NOW(a_last_blocks_input, clk, arst_n, byte_s1.valid && byte_s1.last && !out_free, !in_ch.ready, "input taken while last byte stalled")

	// A pushed result is presented in the next cycle.
	`CIDPE_ASSERT_NEXT(a_push_shows_result, clk, arst_n, res.push, out_ch.valid, "pushed result not presented")

endmodule

### design/cidpe_in_stage.sv
// Input register stage: holds one byte until the parser consumes it.
module cidpe_in_stage
	import cidpe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	cidpe_in_if.sink    in_ch,
	input  logic        adv,
	output byte_t       byte_s1
);

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;

	// The register takes a new byte whenever it is empty or being consumed.
	assign in_ch.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload needs no reset.
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			char_s1 <= in_ch.char_in;
			last_s1 <= in_ch.last;
		end
	end

	assign byte_s1 = '{valid: valid_s1, char_in: char_s1, last: last_s1};

endmodule

### design/cidpe_parser.sv
// Parse state and per-byte next-state logic of the port extractor.
module cidpe_parser
	import cidpe_pkg::*;
#(
	parameter int unsigned PORT_BITS = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  byte_t byte_s1,
	input  logic  out_free,
	output logic  adv,
	output res_t  res
);

	localparam int unsigned SUM_W = PORT_BITS + 4;
	localparam int unsigned EXT_W = (PORT_BITS > PORT_W) ? PORT_BITS : PORT_W;

	typedef enum logic [2:0] {
		PH_START,
		PH_FIND_SP1,
		PH_SKIP_SP1,
		PH_FIND_SP2,
		PH_SKIP_SP2,
		PH_FIND_COLON,
		PH_DONE
	} phase_t;

	phase_t               phase_q, phase_eff, phase_d;
	logic [PORT_BITS-1:0] accum_q, accum_d;
	logic                 frozen_q, frozen_d;
	status_t              decided_q, decided_d;
	logic [CHAR_W-1:0]    c;
	logic                 is_digit;
	logic [3:0]           digit;
	logic [SUM_W-1:0]     sum;
	logic [SUM_W-1:0]     sum_max;
	logic [EXT_W-1:0]     accum_ext;
	status_t              end_status;

	// A byte is consumed unless it ends a string while the result slot is busy.
	assign adv = byte_s1.valid && (!byte_s1.last || out_free);

	assign c        = byte_s1.char_in;
	assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
	assign digit    = 4'(c - CH_ZERO);

	// Multiply by ten as two shifts, add the digit, saturate.
	assign sum     = (SUM_W'(accum_q) << 3) + (SUM_W'(accum_q) << 1) + SUM_W'(digit);
	assign sum_max = SUM_W'({PORT_BITS{1'b1}});

	// Phases that fall through to the next one on this byte.
	always_comb begin
		phase_eff = phase_q;
		if (phase_q == PH_START && c != CH_NUL) begin
			phase_eff = PH_FIND_SP1;
		end else if (phase_q == PH_SKIP_SP1 && c != CH_SPACE) begin
			phase_eff = PH_FIND_SP2;
		end else if (phase_q == PH_SKIP_SP2 && c != CH_SPACE) begin
			phase_eff = PH_FIND_COLON;
		end
	end

	// Next parse state for the byte in the input register.
	always_comb begin
		phase_d   = phase_eff;
		accum_d   = accum_q;
		frozen_d  = frozen_q;
		decided_d = decided_q;
		unique case (phase_eff)
			PH_START: begin
				decided_d = ST_EMPTY;
				phase_d   = PH_DONE;
			end
			PH_FIND_SP1: begin
				if (c == CH_NUL) begin
					decided_d = ST_NO_SP1;
					phase_d   = PH_DONE;
				end else if (c == CH_SPACE) begin
					phase_d = PH_SKIP_SP1;
				end
			end
			PH_FIND_SP2: begin
				if (c == CH_NUL) begin
					decided_d = ST_NO_SP2;
					phase_d   = PH_DONE;
				end else if (c == CH_SPACE) begin
					phase_d = PH_SKIP_SP2;
				end
			end
			PH_FIND_COLON: begin
				if (c == CH_NUL) begin
					decided_d = ST_NO_COLON;
					phase_d   = PH_DONE;
				end else if (c == CH_COLON) begin
					decided_d = ST_OK;
					phase_d   = PH_DONE;
				end else if (c == CH_SLASH || c == CH_SPACE) begin
					accum_d  = '0;
					frozen_d = 1'b0;
				end else if (!frozen_q) begin
					if (is_digit) begin
						accum_d = (sum > sum_max) ? {PORT_BITS{1'b1}} : sum[PORT_BITS-1:0];
					end else begin
						frozen_d = 1'b1;
					end
				end
			end
			PH_SKIP_SP1, PH_SKIP_SP2, PH_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Status given when the string ends in the current phase.
	always_comb begin
		unique case (phase_d)
			PH_DONE:                  end_status = decided_d;
			PH_START, PH_FIND_SP1:    end_status = ST_NO_SP1;
			PH_SKIP_SP1, PH_FIND_SP2: end_status = ST_NO_SP2;
			default:                  end_status = ST_NO_COLON;
		endcase
	end

	assign accum_ext  = EXT_W'(accum_d);
	assign res.push   = adv && byte_s1.last;
	assign res.status = end_status;
	assign res.port   = (end_status == ST_OK) ? accum_ext[PORT_W-1:0] : '0;

	// Parse state; the last byte of a string returns it to the start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_START;
			accum_q   <= '0;
			frozen_q  <= 1'b0;
			decided_q <= ST_OK;
		end else if (adv) begin
			if (byte_s1.last) begin
				phase_q   <= PH_START;
				accum_q   <= '0;
				frozen_q  <= 1'b0;
				decided_q <= ST_OK;
			end else begin
				phase_q   <= phase_d;
				accum_q   <= accum_d;
				frozen_q  <= frozen_d;
				decided_q <= decided_d;
			end
		end
	end

endmodule

### design/cidpe_out_stage.sv
// Output register: holds one result until the sink takes it.
module cidpe_out_stage
	import cidpe_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  res_t         res,
	cidpe_out_if.source  out_ch,
	output logic         out_free
);

	logic              valid_q;
	status_t           status_q;
	logic [PORT_W-1:0] port_q;

	// The slot can take a result if empty or emptied by a transfer this cycle.
	assign out_free = !valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res.push) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.push) begin
			status_q <= res.status;
			port_q   <= res.port;
		end
	end

	assign out_ch.valid  = valid_q;
	assign out_ch.status = status_q;
	assign out_ch.port   = port_q;

endmodule
